// ===== sv/rstab_pkg.sv =====
package rstab_pkg;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_FIND   = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

    localparam int unsigned REF_FIELD_W   = 32;
    localparam int unsigned INDEX_FIELD_W = 9;
    localparam int unsigned FOUND_FIELD_W = 8;

    typedef struct packed {
        kind_t                    kind;
        logic [REF_FIELD_W-1:0]   reference;
        logic [INDEX_FIELD_W-1:0] bottom_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [FOUND_FIELD_W-1:0] found_index;
        logic [INDEX_FIELD_W-1:0] entry_count;
    } out_word_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic search;         // capture hit flags for the word just taken
        logic commit_add;     // write the pushed reference at the top
        logic commit_remove;  // slide entries at and above the match down
    } cell_cmd_t;

endpackage

// ===== sv/rstab_cell.sv =====
module rstab_cell
    import rstab_pkg::*;
#(
    parameter int unsigned REF_WIDTH = 32,
    parameter int unsigned IW        = 9,
    parameter int unsigned INDEX     = 0
) (
    input  logic                 aclk,
    input  cell_cmd_t            cmd,
    input  logic [REF_WIDTH-1:0] search_ref,
    input  logic [IW-1:0]        lo_index,
    input  logic [IW-1:0]        hi_index,
    input  logic [REF_WIDTH-1:0] wr_ref,
    input  logic [REF_WIDTH-1:0] up_entry,
    input  logic                 above_in,
    output logic [REF_WIDTH-1:0] entry_out,
    output logic                 above_out,
    output logic                 sel_out
);

    localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

    logic [REF_WIDTH-1:0] entry_reg;
    logic                 hit_reg;
    logic                 in_range;

    assign in_range = (MY_INDEX >= lo_index) && (MY_INDEX < hi_index);

    always_ff @(posedge aclk) begin
        if (cmd.search) begin
            hit_reg <= in_range && (entry_reg == search_ref);
        end
        if (cmd.commit_add && (MY_INDEX == hi_index)) begin
            entry_reg <= wr_ref;
        end else if (cmd.commit_remove && !above_in) begin
            // at or above the match: take the neighbor's entry
            entry_reg <= up_entry;
        end
    end

    assign entry_out = entry_reg;
    assign above_out = above_in | hit_reg;
    assign sel_out   = hit_reg & ~above_in;

endmodule

// ===== sv/reference_stack_table.sv =====
// a word is taken in ST_IDLE while the cells capture their hit flags; the cell chain
// resolves and commits it in ST_RESOLVE once the output register is free, registering
// the result; a new word is taken only after that commit
// reset: aresetn synchronous active low; clears entry count, handshake state and
//   max_entries (to 256); stored entries are not cleared and hold garbage until pushed
module reference_stack_table
    import rstab_pkg::*;
#(
    parameter int unsigned DEPTH     = 256,
    parameter int unsigned REF_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,

    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data,

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    // common width for index compares against the 9-bit fields
    localparam int unsigned IW = (CW > INDEX_FIELD_W) ? CW : INDEX_FIELD_W;
    localparam logic [IW-1:0] DEPTH_IW = IW'(DEPTH);
    localparam logic REG_MAX_ENTRIES = 1'b0;  // paddr[2] selects the register

    typedef enum logic {
        ST_IDLE,
        ST_RESOLVE
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          count_reg;
    logic [INDEX_FIELD_W-1:0] max_entries_reg;
    kind_t                  kind_reg;
    logic [REF_WIDTH-1:0]   ref_reg;
    logic                   m_valid_reg;
    out_word_t              m_data_reg;

    logic [REF_WIDTH-1:0]   ref_in;
    logic [REF_WIDTH-1:0]   entry_w [DEPTH];
    logic [DEPTH:0]         above_w;
    logic [DEPTH-1:0]       sel_w;
    logic [IW-1:0]          count_iw;
    logic [IW-1:0]          limit_iw;
    logic [IW-1:0]          found_iw;
    logic                   any_hit;
    logic                   accept;
    logic                   commit;
    logic                   add_ok;
    cell_cmd_t              cmd;
    out_word_t              result_next;
    logic [CW-1:0]          count_next;

    // only the low REF_WIDTH bits of a reference are kept; a wider REF_WIDTH zero-extends it
    generate
        if (REF_WIDTH <= REF_FIELD_W) begin : g_ref_narrow
            assign ref_in = s_data.reference[REF_WIDTH-1:0];
        end else begin : g_ref_wide
            assign ref_in = {{(REF_WIDTH - REF_FIELD_W){1'b0}}, s_data.reference};
        end
    endgenerate

    // config port, no wait states
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_ENTRIES) ? 32'(max_entries_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= INDEX_FIELD_W'(256);
        end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_ENTRIES)) begin
            max_entries_reg <= pwdata[INDEX_FIELD_W-1:0];
        end
    end

    // handshake: one word in flight, output register decouples the result side
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign commit  = (state_reg == ST_RESOLVE) && (!m_valid_reg || m_ready);

    assign count_iw = IW'(count_reg);
    // limit saturates at the physical depth
    assign limit_iw = (IW'(max_entries_reg) > DEPTH_IW) ? DEPTH_IW : IW'(max_entries_reg);
    assign add_ok   = count_iw < limit_iw;
    assign any_hit  = above_w[0];

    assign cmd.search        = accept;
    assign cmd.commit_add    = commit && (kind_reg == KIND_ADD) && add_ok;
    assign cmd.commit_remove = commit && (kind_reg == KIND_REMOVE) && any_hit;

    // nothing above the top cell
    assign above_w[DEPTH] = 1'b0;

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            logic [REF_WIDTH-1:0] up_entry;
            if (i == DEPTH - 1) begin : g_top
                assign up_entry = '0;
            end else begin : g_mid
                assign up_entry = entry_w[i+1];
            end
            rstab_cell #(
                .REF_WIDTH (REF_WIDTH),
                .IW        (IW),
                .INDEX     (i)
            ) u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .search_ref (ref_in),
                .lo_index   (IW'(s_data.bottom_index)),
                .hi_index   (count_iw),
                .wr_ref     (ref_reg),
                .up_entry   (up_entry),
                .above_in   (above_w[i+1]),
                .entry_out  (entry_w[i]),
                .above_out  (above_w[i]),
                .sel_out    (sel_w[i])
            );
        end
    endgenerate

    // one-hot topmost hit to index
    always_comb begin
        found_iw = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (sel_w[i]) begin
                found_iw = found_iw | IW'(i);
            end
        end
    end

    // result and new count for the word being resolved
    always_comb begin
        result_next = '0;
        count_next  = count_reg;
        case (kind_reg)
            KIND_ADD: begin
                if (add_ok) begin
                    result_next.status      = STATUS_OK;
                    result_next.found_index = count_iw[FOUND_FIELD_W-1:0];
                    count_next              = count_reg + CW'(1);
                end else begin
                    result_next.status = STATUS_OVERFLOW;
                end
            end
            KIND_FIND, KIND_REMOVE: begin
                if (any_hit) begin
                    result_next.status      = STATUS_OK;
                    result_next.found_index = found_iw[FOUND_FIELD_W-1:0];
                    if (kind_reg == KIND_REMOVE) begin
                        count_next = count_reg - CW'(1);
                    end
                end else begin
                    result_next.status = STATUS_NOTFOUND;
                end
            end
            KIND_CLEAR: begin
                result_next.status = STATUS_OK;
                count_next         = '0;
            end
            default: begin
                result_next.status = STATUS_OK;
            end
        endcase
        result_next.entry_count = IW'(count_next) > 0 ?
            INDEX_FIELD_W'(count_next) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_RESOLVE;
                    end
                end
                ST_RESOLVE: begin
                    if (commit) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (commit) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // word payload, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_data.kind;
            ref_reg  <= ref_in;
        end
        if (commit) begin
            m_data_reg <= result_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
